// ----- rtl/grid_line_of_sight_check_defines.svh -----
// Assertion macros used by the checker file.
`ifndef GRID_LINE_OF_SIGHT_CHECK_DEFINES_SVH
`define GRID_LINE_OF_SIGHT_CHECK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GLOS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line-of-sight check assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GLOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line-of-sight check assertion failed");

`endif

// ----- rtl/glos_pkg.sv -----
package glos_pkg;

  localparam int unsigned GRID_WIDTH  = 256;
  localparam int unsigned GRID_HEIGHT = 256;

  localparam int unsigned XW      = $clog2(GRID_WIDTH);
  localparam int unsigned YW      = $clog2(GRID_HEIGHT);
  localparam int unsigned ADDR_W  = XW + YW;
  localparam int unsigned DEPTH   = 2 ** ADDR_W;
  localparam int unsigned GRID_MAX_W = (XW > YW) ? XW : YW;
  localparam int unsigned COORD_W = ((GRID_MAX_W > 8) ? GRID_MAX_W : 8) + 2;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [ADDR_W-1:0]         addr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_PROBE,
    ST_LAST,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [7:0] maj;
    logic [7:0] min;
    logic [7:0] dmaj;
    logic [7:0] dmin;
    logic [7:0] err;
    logic       maj_neg;
    logic       min_neg;
    logic       x_major;
    logic       aligned;
  } walk_t;

  typedef struct packed {
    logic [7:0] maj_next;
    logic [7:0] min_next;
    logic [7:0] err_next;
    addr_t      p0_addr;
    logic       p0_vld;
    addr_t      p1_addr;
    logic       p1_vld;
  } step_t;

  function automatic coord_t to_coord(input logic [7:0] v);
    return coord_t'({{(COORD_W-8){1'b0}}, v});
  endfunction

  function automatic logic in_grid(input coord_t x, input coord_t y);
    return (x >= 0) && (x < coord_t'(GRID_WIDTH)) && (y >= 0) && (y < coord_t'(GRID_HEIGHT));
  endfunction

  function automatic addr_t cell_addr(input coord_t x, input coord_t y);
    return (addr_t'(unsigned'(y)) << XW) | addr_t'(unsigned'(x));
  endfunction

endpackage

// ----- rtl/glos_ram.sv -----
module glos_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/glos_step.sv -----
module glos_step (
  input  glos_pkg::walk_t walk_i,
  output glos_pkg::step_t step_o
);
  import glos_pkg::*;

  logic [8:0] err_sum;
  logic       take;
  logic [8:0] err_rem;
  logic [7:0] min_new;
  coord_t     maj_p;
  coord_t     min_c;
  coord_t     min_old_p;
  coord_t     min_new_p;
  coord_t     min_m1;
  coord_t     p0_min;
  coord_t     p1_min;
  coord_t     p0_x;
  coord_t     p0_y;
  coord_t     p1_x;
  coord_t     p1_y;

  always_comb begin
    err_sum = {1'b0, walk_i.err} + {1'b0, walk_i.dmin};
    take    = (err_sum >= {1'b0, walk_i.dmaj});
    err_rem = take ? (err_sum - {1'b0, walk_i.dmaj}) : err_sum;
    if (take) begin
      min_new = walk_i.min_neg ? (walk_i.min - 8'd1) : (walk_i.min + 8'd1);
    end else begin
      min_new = walk_i.min;
    end

    maj_p     = to_coord(walk_i.maj) - (walk_i.maj_neg ? coord_t'(1) : coord_t'(0));
    min_c     = to_coord(walk_i.min);
    min_old_p = min_c - (walk_i.min_neg ? coord_t'(1) : coord_t'(0));
    min_new_p = to_coord(min_new) - (walk_i.min_neg ? coord_t'(1) : coord_t'(0));
    min_m1    = min_c - coord_t'(1);

    // On an axis-aligned walk the two probes are the cells on either side of the line.
    p0_min = walk_i.aligned ? min_c  : min_old_p;
    p1_min = walk_i.aligned ? min_m1 : min_new_p;

    p0_x = walk_i.x_major ? maj_p  : p0_min;
    p0_y = walk_i.x_major ? p0_min : maj_p;
    p1_x = walk_i.x_major ? maj_p  : p1_min;
    p1_y = walk_i.x_major ? p1_min : maj_p;

    step_o.maj_next = walk_i.maj_neg ? (walk_i.maj - 8'd1) : (walk_i.maj + 8'd1);
    step_o.min_next = min_new;
    step_o.err_next = err_rem[7:0];
    step_o.p0_addr  = cell_addr(p0_x, p0_y);
    step_o.p0_vld   = (walk_i.aligned || take) && in_grid(p0_x, p0_y);
    step_o.p1_addr  = cell_addr(p1_x, p1_y);
    step_o.p1_vld   = (walk_i.aligned || (err_rem != 9'd0)) && in_grid(p1_x, p1_y);
  end

endmodule

// ----- rtl/grid_line_of_sight_check.sv -----
// A write item is taken while idle, gives no result, and writes can follow back to back.
// A query walks the cell steps along the major axis, reading one probe cell in ST_STEP
// and the other in ST_PROBE, then passes ST_LAST to ST_DONE; a hit ends the walk sooner.
// Start equal to end skips to ST_DONE. Input is ready the cycle after the result.
// The single grid memory port allows one probe read per cycle.
// Reset clears the sequencer; the grid keeps its contents and must be loaded first.
module grid_line_of_sight_check (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       kind_i,
  input  logic [7:0] first_x_i,
  input  logic [7:0] first_y_i,
  input  logic       occupied_i,
  input  logic [7:0] second_x_i,
  input  logic [7:0] second_y_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       visible_o
);
  import glos_pkg::*;

  state_e     state_q, state_d;
  walk_t      walk_q, walk_d;
  logic [7:0] maj_end_q, maj_end_d;
  addr_t      p1_addr_q, p1_addr_d;
  logic       p1_vld_q, p1_vld_d;
  logic       chk0_q, chk0_d;
  logic       chk1_q, chk1_d;
  logic       side_q, side_d;
  logic       visible_q, visible_d;

  step_t      step;
  logic       in_acc;
  logic       wr_en;
  addr_t      wr_addr;
  addr_t      rd_addr;
  logic       rd_data;
  coord_t     fx_c;
  coord_t     fy_c;
  logic [8:0] dx_s;
  logic [8:0] dy_s;
  logic [7:0] adx;
  logic [7:0] ady;
  logic       x_major;
  logic       hit1;
  logic       hit0;

  glos_step u_step (
    .walk_i (walk_q),
    .step_o (step)
  );

  glos_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (occupied_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_DONE);
  assign visible_o   = visible_q;
  assign in_acc      = in_valid_i && in_ready_o;

  always_comb begin
    fx_c    = to_coord(first_x_i);
    fy_c    = to_coord(first_y_i);
    wr_addr = cell_addr(fx_c, fy_c);
    wr_en   = in_acc && (kind_i == KIND_WRITE) && in_grid(fx_c, fy_c);

    dx_s    = {1'b0, second_x_i} - {1'b0, first_x_i};
    dy_s    = {1'b0, second_y_i} - {1'b0, first_y_i};
    adx     = dx_s[8] ? 8'(-dx_s) : dx_s[7:0];
    ady     = dy_s[8] ? 8'(-dy_s) : dy_s[7:0];
    x_major = (adx >= ady);

    // A probe hit of the second kind counts alone, or together with its partner on
    // an axis-aligned walk.
    hit1 = chk1_q && rd_data && (!walk_q.aligned || side_q);
    hit0 = chk0_q && rd_data;
  end

  always_comb begin
    state_d   = state_q;
    walk_d    = walk_q;
    maj_end_d = maj_end_q;
    p1_addr_d = p1_addr_q;
    p1_vld_d  = p1_vld_q;
    chk0_d    = chk0_q;
    chk1_d    = chk1_q;
    side_d    = side_q;
    visible_d = visible_q;
    rd_addr   = p1_addr_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (kind_i == KIND_QUERY)) begin
          walk_d.x_major = x_major;
          walk_d.maj     = x_major ? first_x_i : first_y_i;
          walk_d.min     = x_major ? first_y_i : first_x_i;
          walk_d.dmaj    = x_major ? adx : ady;
          walk_d.dmin    = x_major ? ady : adx;
          walk_d.maj_neg = x_major ? dx_s[8] : dy_s[8];
          walk_d.min_neg = x_major ? dy_s[8] : dx_s[8];
          walk_d.aligned = x_major ? (ady == 8'd0) : (adx == 8'd0);
          walk_d.err     = 8'd0;
          maj_end_d      = x_major ? second_x_i : second_y_i;
          chk1_d         = 1'b0;
          side_d         = 1'b0;
          visible_d      = 1'b1;
          if ((first_x_i == second_x_i) && (first_y_i == second_y_i)) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_STEP;
          end
        end
      end
      ST_STEP: begin
        rd_addr = step.p0_addr;
        if (hit1) begin
          visible_d = 1'b0;
          state_d   = ST_DONE;
        end else begin
          walk_d.maj = step.maj_next;
          walk_d.min = step.min_next;
          walk_d.err = step.err_next;
          p1_addr_d  = step.p1_addr;
          p1_vld_d   = step.p1_vld;
          chk0_d     = step.p0_vld;
          state_d    = ST_PROBE;
        end
      end
      ST_PROBE: begin
        rd_addr = p1_addr_q;
        side_d  = hit0;
        chk1_d  = p1_vld_q;
        if (hit0 && !walk_q.aligned) begin
          visible_d = 1'b0;
          state_d   = ST_DONE;
        end else if (walk_q.maj == maj_end_q) begin
          state_d = ST_LAST;
        end else begin
          state_d = ST_STEP;
        end
      end
      ST_LAST: begin
        visible_d = !hit1;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chk0_q  <= 1'b0;
      chk1_q  <= 1'b0;
      side_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      chk0_q  <= chk0_d;
      chk1_q  <= chk1_d;
      side_q  <= side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    walk_q    <= walk_d;
    maj_end_q <= maj_end_d;
    p1_addr_q <= p1_addr_d;
    p1_vld_q  <= p1_vld_d;
    visible_q <= visible_d;
  end

endmodule

// ----- rtl/glos_checker.sv -----
`include "grid_line_of_sight_check_defines.svh"

module glos_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic kind_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic visible_o
);
  import glos_pkg::*;

  logic in_acc;
  logic out_acc;
  logic wr_acc;
  logic qry_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign wr_acc  = in_acc && (kind_i == KIND_WRITE);
  assign qry_acc = in_acc && (kind_i == KIND_QUERY);

  `GLOS_ASSERT_SAME(a_no_overlap, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `GLOS_ASSERT_NEXT(a_write_no_result, clk_i, rst_ni, wr_acc, in_ready_o && !out_valid_o)
  `GLOS_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, qry_acc, !in_ready_o)
  `GLOS_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(visible_o))
  `GLOS_ASSERT_NEXT(a_ready_after_result, clk_i, rst_ni, out_acc, in_ready_o && !out_valid_o)

endmodule

bind grid_line_of_sight_check glos_checker u_glos_checker (.*);

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import glos_pkg::*;

  typedef struct {
    int  x0;
    int  y0;
    int  x1;
    int  y1;
    bit  clear;
  } sight_query_t;

  class sight_scoreboard;
    bit           blocked_map [0:GRID_WIDTH*GRID_HEIGHT-1];
    bit           written_map [0:GRID_WIDTH*GRID_HEIGHT-1];
    sight_query_t visible_due [$];
    int           need_x [$];
    int           need_y [$];
    int unsigned  fails;

    function void report(string what);
      if (fails < 50) begin
        $display("%0t mismatch: %s", $realtime, what);
      end
      fails++;
    endfunction

    function bit cell_hit(int x, int y);
      if (x < 0 || y < 0 || x >= int'(GRID_WIDTH) || y >= int'(GRID_HEIGHT)) begin
        return 1'b0;
      end
      return blocked_map[y * int'(GRID_WIDTH) + x];
    endfunction

    function bit cell_written(int x, int y);
      return written_map[y * int'(GRID_WIDTH) + x];
    endfunction

    function void add_need(int x, int y);
      if (x >= 0 && y >= 0 && x < int'(GRID_WIDTH) && y < int'(GRID_HEIGHT)) begin
        need_x = {need_x, x};
        need_y = {need_y, y};
      end
    endfunction

    // Walk along the major axis with a running error term, probing the cell
    // that the segment enters at each step.
    function bit segment_clear(int ax, int ay, int bx, int by);
      int run_x;
      int run_y;
      int step_x;
      int step_y;
      int off_x;
      int off_y;
      int acc;
      run_x  = bx - ax;
      run_y  = by - ay;
      step_x = 1;
      step_y = 1;
      acc    = 0;
      if (run_x < 0) begin
        run_x  = -run_x;
        step_x = -1;
      end
      if (run_y < 0) begin
        run_y  = -run_y;
        step_y = -1;
      end
      off_x = (step_x < 0) ? -1 : 0;
      off_y = (step_y < 0) ? -1 : 0;
      if (run_x >= run_y) begin
        while (ax != bx) begin
          acc += run_y;
          if (acc >= run_x) begin
            if (cell_hit(ax + off_x, ay + off_y)) return 1'b0;
            ay  += step_y;
            acc -= run_x;
          end
          if (acc != 0 && cell_hit(ax + off_x, ay + off_y)) return 1'b0;
          if (run_y == 0 && cell_hit(ax + off_x, ay) && cell_hit(ax + off_x, ay - 1)) begin
            return 1'b0;
          end
          ax += step_x;
        end
      end else begin
        while (ay != by) begin
          acc += run_x;
          if (acc >= run_y) begin
            if (cell_hit(ax + off_x, ay + off_y)) return 1'b0;
            ax  += step_x;
            acc -= run_y;
          end
          if (acc != 0 && cell_hit(ax + off_x, ay + off_y)) return 1'b0;
          if (run_x == 0 && cell_hit(ax, ay + off_y) && cell_hit(ax - 1, ay + off_y)) begin
            return 1'b0;
          end
          ay += step_y;
        end
      end
      return 1'b1;
    endfunction

    // Collect every grid cell that a query along this segment may read.
    function void list_path(int ax, int ay, int bx, int by);
      int run_x;
      int run_y;
      int step_x;
      int step_y;
      int off_x;
      int off_y;
      int acc;
      need_x.delete();
      need_y.delete();
      run_x  = bx - ax;
      run_y  = by - ay;
      step_x = 1;
      step_y = 1;
      acc    = 0;
      if (run_x < 0) begin
        run_x  = -run_x;
        step_x = -1;
      end
      if (run_y < 0) begin
        run_y  = -run_y;
        step_y = -1;
      end
      off_x = (step_x < 0) ? -1 : 0;
      off_y = (step_y < 0) ? -1 : 0;
      if (run_x >= run_y) begin
        while (ax != bx) begin
          acc += run_y;
          if (acc >= run_x) begin
            add_need(ax + off_x, ay + off_y);
            ay  += step_y;
            acc -= run_x;
          end
          if (acc != 0) add_need(ax + off_x, ay + off_y);
          if (run_y == 0) begin
            add_need(ax + off_x, ay);
            add_need(ax + off_x, ay - 1);
          end
          ax += step_x;
        end
      end else begin
        while (ay != by) begin
          acc += run_x;
          if (acc >= run_y) begin
            add_need(ax + off_x, ay + off_y);
            ax  += step_x;
            acc -= run_y;
          end
          if (acc != 0) add_need(ax + off_x, ay + off_y);
          if (run_x == 0) begin
            add_need(ax, ay + off_y);
            add_need(ax - 1, ay + off_y);
          end
          ay += step_y;
        end
      end
    endfunction

    function void note_item(logic kind, logic [7:0] fx, logic [7:0] fy, logic occ,
                            logic [7:0] sx, logic [7:0] sy);
      sight_query_t q;
      if (kind == KIND_WRITE) begin
        if (int'(fx) < int'(GRID_WIDTH) && int'(fy) < int'(GRID_HEIGHT)) begin
          blocked_map[int'(fy) * int'(GRID_WIDTH) + int'(fx)] = occ;
          written_map[int'(fy) * int'(GRID_WIDTH) + int'(fx)] = 1'b1;
        end
      end else begin
        q.x0    = int'(fx);
        q.y0    = int'(fy);
        q.x1    = int'(sx);
        q.y1    = int'(sy);
        q.clear = segment_clear(q.x0, q.y0, q.x1, q.y1);
        visible_due = {visible_due, q};
      end
    endfunction

    function void check_result(logic vis);
      sight_query_t q;
      if (visible_due.size() == 0) begin
        report($sformatf("visible=%b with no query pending", vis));
        return;
      end
      q = visible_due.pop_front();
      if (vis !== q.clear) begin
        report($sformatf("query (%0d,%0d)->(%0d,%0d): visible=%b, want %b",
                         q.x0, q.y0, q.x1, q.y1, vis, q.clear));
      end
    endfunction

    function void check_drained();
      if (visible_due.size() != 0) begin
        report($sformatf("%0d queries never answered", visible_due.size()));
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic       kind_i;
  logic [7:0] first_x_i;
  logic [7:0] first_y_i;
  logic       occupied_i;
  logic [7:0] second_x_i;
  logic [7:0] second_y_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       visible_o;

  sight_scoreboard board = new();
  int          burst_left = 0;
  int unsigned sent_count = 0;
  bit          hold_armed = 1'b0;
  int          fill_pct   = 0;

  grid_line_of_sight_check uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .first_x_i   (first_x_i),
    .first_y_i   (first_y_i),
    .occupied_i  (occupied_i),
    .second_x_i  (second_x_i),
    .second_y_i  (second_y_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .visible_o   (visible_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(50_000_000);
    $display("FAIL grid_line_of_sight_check");
    $finish;
  end

  function automatic logic [7:0] clamp8(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return 8'(v);
  endfunction

  function automatic int window_coord();
    if ($urandom_range(0, 1) == 0) begin
      return int'($urandom_range(0, 15));
    end
    return int'($urandom_range(240, 255));
  endfunction

  task automatic send_item(logic kind, logic [7:0] fx, logic [7:0] fy, logic occ,
                           logic [7:0] sx, logic [7:0] sy);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    first_x_i  <= fx;
    first_y_i  <= fy;
    occupied_i <= occ;
    second_x_i <= sx;
    second_y_i <= sy;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    board.note_item(kind, fx, fy, occ, sx, sy);
    sent_count++;
  endtask

  task automatic write_cell(int x, int y, logic occ);
    send_item(KIND_WRITE, clamp8(x), clamp8(y), occ, 8'($urandom), 8'($urandom));
  endtask

  // Every cell that a query reads is written before the query is sent.
  task automatic load_path(int ax, int ay, int bx, int by);
    int cx [$];
    int cy [$];
    board.list_path(ax, ay, bx, by);
    cx = board.need_x;
    cy = board.need_y;
    foreach (cx[i]) begin
      if (!board.cell_written(cx[i], cy[i])) begin
        write_cell(cx[i], cy[i], ($urandom_range(0, 99) < fill_pct));
      end
    end
  endtask

  task automatic ask_sight(int ax, int ay, int bx, int by);
    logic [7:0] fx;
    logic [7:0] fy;
    logic [7:0] tx;
    logic [7:0] ty;
    fx = clamp8(ax);
    fy = clamp8(ay);
    tx = clamp8(bx);
    ty = clamp8(by);
    load_path(int'(fx), int'(fy), int'(tx), int'(ty));
    send_item(KIND_QUERY, fx, fy, 1'($urandom), tx, ty);
  endtask

  // One query, sometimes with obstacles placed on or beside its path beforehand, and
  // sometimes the same path asked again after they are removed.
  task automatic run_query_group();
    int ax;
    int ay;
    int bx;
    int by;
    int reach;
    int pick;
    int n_marks;
    int t;
    int px;
    int py;
    int mark_x [$];
    int mark_y [$];
    ax   = window_coord();
    ay   = window_coord();
    pick = $urandom_range(0, 99);
    reach = (pick < 75) ? 6 : (pick < 95) ? 12 : 40;
    bx = int'(clamp8(ax + int'($urandom_range(0, 2 * reach)) - reach));
    by = int'(clamp8(ay + int'($urandom_range(0, 2 * reach)) - reach));
    pick = $urandom_range(0, 99);
    if (pick < 14) begin
      by = ay;
    end else if (pick < 28) begin
      bx = ax;
    end else if (pick < 32) begin
      bx = ax;
      by = ay;
    end else if (pick < 40) begin
      by = int'(clamp8(ay + ((pick[0]) ? (bx - ax) : (ax - bx))));
    end
    n_marks = ($urandom_range(0, 9) < 5) ? $urandom_range(1, 2) : 0;
    repeat (n_marks) begin
      t  = $urandom_range(0, 16);
      px = ax + (bx - ax) * t / 16;
      py = ay + (by - ay) * t / 16;
      if ((ax == bx || ay == by) && $urandom_range(0, 1) == 1) begin
        mark_x = {mark_x, px};
        mark_y = {mark_y, py};
        mark_x = {mark_x, (ay == by) ? px : px - 1};
        mark_y = {mark_y, (ay == by) ? py - 1 : py};
      end else begin
        mark_x = {mark_x, px + int'($urandom_range(0, 2)) - 1};
        mark_y = {mark_y, py + int'($urandom_range(0, 2)) - 1};
      end
    end
    foreach (mark_x[i]) write_cell(mark_x[i], mark_y[i], 1'b1);
    ask_sight(ax, ay, bx, by);
    if (mark_x.size() != 0 && $urandom_range(0, 1) == 1) begin
      foreach (mark_x[i]) write_cell(mark_x[i], mark_y[i], 1'b0);
      if ($urandom_range(0, 1) == 1) begin
        ask_sight(bx, by, ax, ay);
      end else begin
        ask_sight(ax, ay, bx, by);
      end
    end
  endtask

  initial begin
    int mode;
    int left;
    int tick;
    out_ready_i = 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      left = $urandom_range(20, 200);
      repeat (left) begin
        @(negedge clk_i);
        tick++;
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 3) != 0);
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ((tick % 5) < 2);
        endcase
      end
      if (hold_armed) begin
        hold_armed = 1'b0;
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (3000) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      board.check_result(visible_o);
    end
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    kind_i     = KIND_WRITE;
    first_x_i  = '0;
    first_y_i  = '0;
    occupied_i = 1'b0;
    second_x_i = '0;
    second_y_i = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    fill_pct = 0;
    write_cell(0, 0, 1'b0);
    ask_sight(0, 0, 0, 0);
    ask_sight(255, 255, 255, 255);
    ask_sight(255, 0, 0, 255);
    ask_sight(0, 255, 255, 0);
    write_cell(100, 50, 1'b1);
    write_cell(100, 49, 1'b1);
    ask_sight(90, 50, 110, 50);
    ask_sight(110, 50, 90, 50);
    write_cell(30, 200, 1'b1);
    write_cell(29, 200, 1'b1);
    ask_sight(30, 190, 30, 210);
    ask_sight(30, 210, 30, 190);
    write_cell(60, 0, 1'b1);
    ask_sight(50, 0, 70, 0);
    write_cell(0, 60, 1'b1);
    ask_sight(0, 50, 0, 70);
    ask_sight(10, 10, 12, 11);

    fill_pct   = 3;
    hold_armed = 1'b1;
    while (sent_count < 900) begin
      if ($urandom_range(0, 99) < 15) begin
        write_cell(window_coord(), window_coord(), ($urandom_range(0, 3) == 0));
      end else begin
        run_query_group();
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (board.visible_due.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    board.check_drained();
    if (board.fails == 0) begin
      $display("PASS grid_line_of_sight_check");
    end else begin
      $display("FAIL grid_line_of_sight_check");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/glos_pkg.sv
rtl/glos_ram.sv
rtl/glos_step.sv
rtl/grid_line_of_sight_check.sv
rtl/glos_checker.sv
verif/tb_top.sv
